// ===== design/lmrs_pkg.sv =====
// Shared types and constants for the LED matrix row scan unit.
// Pixel flag layout, plane codes, request codes and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmrs_pkg;

  // Fixed field widths of the request and result ports
  localparam int XW        = 6;
  localparam int YW        = 5;
  localparam int CHW       = 8;
  localparam int BYTE_W    = 8;
  localparam int BIDX_W    = 6;
  localparam int ROWSEL_W  = 4;

  // Request codes
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // One stored pixel: one lit flag per colour
  localparam int PIX_W        = 3;
  localparam int LIT_RED_BIT   = 0;
  localparam int LIT_GREEN_BIT = 1;
  localparam int LIT_BLUE_BIT  = 2;

  typedef logic [PIX_W-1:0] pix_t;

  // Position of the last bit within a serial byte
  localparam logic [2:0] BIT_LAST = 3'd7;

  // Plane order within each half of the panel
  typedef enum logic [1:0] {
    PLANE_BLUE,
    PLANE_GREEN,
    PLANE_RED
  } plane_t;

  // One serial byte with its side fields
  typedef struct packed {
    logic [BYTE_W-1:0]   serial_byte;
    logic [BIDX_W-1:0]   byte_index;
    logic                last_byte;
    logic [ROWSEL_W-1:0] row_select;
    logic                display_on;
  } out_item_t;

  // Pick the flag of one plane out of a stored pixel
  function automatic logic plane_bit(input plane_t p, input pix_t v);
    logic b;
    case (p)
      PLANE_BLUE:  b = v[LIT_BLUE_BIT];
      PLANE_GREEN: b = v[LIT_GREEN_BIT];
      PLANE_RED:   b = v[LIT_RED_BIT];
      default:     b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/lmrs_frame_store.sv =====
// Frame store: one pixel flag set per canvas pixel, one write and one read port.
// Runs a clearing pass over every entry after reset; uses lmrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmrs_frame_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire lmrs_pkg::pix_t    wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output lmrs_pkg::pix_t         rd_data,
  output logic                   clearing
);

  lmrs_pkg::pix_t mem [DEPTH];

  logic [AW-1:0]  clr_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  lmrs_pkg::pix_t mem_wdata;

  // Clearing pass owns the write port until every entry is zero
  always_comb begin
    mem_we    = clearing | wr_en;
    mem_waddr = clearing ? clr_addr : wr_addr;
    mem_wdata = clearing ? '0 : wr_data;
  end

  // Advance the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/lmrs_scan_seq.sv =====
// Scan sequencer: walks one scan line bit by bit through the frame store,
// packs the plane bits into serial bytes and holds them in an output register.
// Uses lmrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmrs_scan_seq #(
  parameter int COLUMNS       = 64,
  parameter int ROWS_PER_HALF = 16,
  parameter int AW            = 11
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  wire lmrs_pkg::pix_t      rd_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lmrs_pkg::out_item_t      out_item
);

  localparam int TOTAL_BITS  = 6 * COLUMNS;
  localparam int TOTAL_BYTES = (TOTAL_BITS + 7) / 8;
  localparam int LW          = $clog2(ROWS_PER_HALF);
  localparam int RW          = $clog2(2 * ROWS_PER_HALF);
  localparam int CL          = $clog2(COLUMNS);
  localparam int KW          = $clog2(TOTAL_BYTES);

  localparam logic [AW-1:0] COLS_A   = AW'(COLUMNS);
  localparam logic [CL-1:0] COL_LAST = CL'(COLUMNS - 1);
  localparam logic [KW-1:0] BYTE_END = KW'(TOTAL_BYTES - 1);
  localparam logic [LW-1:0] LINE_END = LW'(ROWS_PER_HALF - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_PUSH
  } state_t;

  state_t           state;
  logic [LW-1:0]    line;
  logic [LW-1:0]    line_next;
  logic             half;
  lmrs_pkg::plane_t plane;
  logic [CL-1:0]    col;
  logic             done_bits;
  logic [2:0]       bit_cnt;
  logic [KW-1:0]    byte_cnt;
  logic             pend_live;
  logic             pend_read;
  lmrs_pkg::plane_t pend_plane;
  logic             pend_bit;
  logic [7:0]       acc;
  logic             out_free;
  logic             push;
  logic             last;
  logic [RW-1:0]    row_base;
  logic [RW-1:0]    row;
  logic [CL-1:0]    mcol;
  logic [KW+lmrs_pkg::BIDX_W-1:0]   bidx_ext;
  logic [LW+lmrs_pkg::ROWSEL_W-1:0] line_ext;

  // Address of the current bit: mirrored column, row counted down from the half's end
  always_comb begin
    row_base = half ? RW'(2 * ROWS_PER_HALF - 1) : RW'(ROWS_PER_HALF - 1);
    row      = row_base - RW'(line);
    mcol     = COL_LAST - col;
    rd_addr  = AW'(row) * COLS_A + AW'(mcol);
    rd_en    = (state == S_READ) && !done_bits;
  end

  always_comb begin
    busy      = (state != S_IDLE);
    out_free  = !out_valid || !out_stall;
    push      = (state == S_PUSH) && out_free;
    last      = (byte_cnt == BYTE_END);
    line_next = (line == LINE_END) ? '0 : line + LW'(1);
    pend_bit  = pend_read & lmrs_pkg::plane_bit(pend_plane, rd_data);
    bidx_ext  = {{lmrs_pkg::BIDX_W{1'b0}}, byte_cnt};
    line_ext  = {{lmrs_pkg::ROWSEL_W{1'b0}}, line};
  end

  // Sequencer state, bit walk counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      line      <= '0;
      out_valid <= 1'b0;
      pend_live <= 1'b0;
      pend_read <= 1'b0;
    end else begin
      // Track the read in flight and shift its bit in once its registered data is back
      pend_live  <= (state == S_READ);
      pend_read  <= rd_en;
      pend_plane <= plane;
      if (pend_live) begin
        acc <= {acc[6:0], pend_bit};
      end

      // Load the held byte on a push, drop it once taken
      out_valid <= push | (out_valid & out_stall);

      case (state)
        S_IDLE: begin
          if (start) begin
            half      <= 1'b0;
            plane     <= lmrs_pkg::PLANE_BLUE;
            col       <= '0;
            done_bits <= 1'b0;
            bit_cnt   <= '0;
            byte_cnt  <= '0;
            state     <= S_READ;
          end
        end
        S_READ: begin
          bit_cnt <= bit_cnt + 3'd1;
          // Advance column, then plane, then half
          if (!done_bits) begin
            if (col == COL_LAST) begin
              col <= '0;
              case (plane)
                lmrs_pkg::PLANE_BLUE:  plane <= lmrs_pkg::PLANE_GREEN;
                lmrs_pkg::PLANE_GREEN: plane <= lmrs_pkg::PLANE_RED;
                default: begin
                  plane <= lmrs_pkg::PLANE_BLUE;
                  if (half) begin
                    done_bits <= 1'b1;
                  end
                  half <= 1'b1;
                end
              endcase
            end else begin
              col <= col + CL'(1);
            end
          end
          if (bit_cnt == lmrs_pkg::BIT_LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          // Hand the finished byte over when the output register is free
          if (out_free) begin
            out_item.serial_byte <= acc;
            out_item.byte_index  <= bidx_ext[lmrs_pkg::BIDX_W-1:0];
            out_item.last_byte   <= last;
            out_item.row_select  <= last ? line_ext[lmrs_pkg::ROWSEL_W-1:0] : '0;
            out_item.display_on  <= last;
            if (last) begin
              line  <= line_next;
              state <= S_IDLE;
            end else begin
              byte_cnt <= byte_cnt + KW'(1);
              bit_cnt  <= '0;
              state    <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_disp_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.display_on == out_item.last_byte))
    else $error("display enable seen off the last byte");

  a_read_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && bit_cnt == lmrs_pkg::BIT_LAST) |=> (state == S_DRAIN))
    else $error("byte read phase did not end after eight bits");

  a_line_adv: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUSH && out_free && last) |=> (line == $past(line_next)))
    else $error("scan line did not advance after the last byte");

  a_byte_range: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (byte_cnt <= BYTE_END))
    else $error("byte counter ran past the row transfer");

  a_free_push: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("held byte dropped while stalled");
`endif

endmodule

`default_nettype wire

// ===== design/led_matrix_row_scan_unit.sv =====
// Pixel write: one per cycle while req_stall is low, no result.
// Refresh tick: each serial byte takes one frame store read per bit, then a drain and
//   a push into the output register, which holds the byte while byte_stall is high.
// Reset: synchronous; a clearing pass over all 2*ROWS_PER_HALF*COLUMNS entries (2048 at
//   default) zeroes the frame store while req_stall stays high.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_row_scan_unit #(
  parameter int COLUMNS       = 64,
  parameter int ROWS_PER_HALF = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire logic                          req_type,
  input  wire logic [lmrs_pkg::XW-1:0]       pixel_x,
  input  wire logic [lmrs_pkg::YW-1:0]       pixel_y,
  input  wire logic [lmrs_pkg::CHW-1:0]      red,
  input  wire logic [lmrs_pkg::CHW-1:0]      green,
  input  wire logic [lmrs_pkg::CHW-1:0]      blue,
  output logic                               byte_valid,
  input  wire logic                          byte_stall,
  output logic [lmrs_pkg::BYTE_W-1:0]        serial_byte,
  output logic [lmrs_pkg::BIDX_W-1:0]        byte_index,
  output logic                               last_byte,
  output logic [lmrs_pkg::ROWSEL_W-1:0]      row_select,
  output logic                               display_on
);

  localparam int DEPTH = 2 * ROWS_PER_HALF * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  logic                accept;
  logic                in_range;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  lmrs_pkg::pix_t      wr_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  lmrs_pkg::pix_t      rd_data;
  logic                clearing;
  logic                seq_busy;
  logic                start;
  lmrs_pkg::out_item_t out_item;

  // Hold requests during the clearing pass and while a tick is in progress
  assign req_stall = clearing | seq_busy;
  assign accept    = req_valid & ~req_stall;

  // Drop writes that fall outside the panel
  always_comb begin
    in_range = ({{(32 - lmrs_pkg::XW){1'b0}}, pixel_x} < 32'(COLUMNS)) &&
               ({{(32 - lmrs_pkg::YW){1'b0}}, pixel_y} < 32'(2 * ROWS_PER_HALF));
    wr_en    = accept && (req_type == lmrs_pkg::REQ_PIXEL) && in_range;
    start    = accept && (req_type == lmrs_pkg::REQ_TICK);
    wr_addr  = AW'(pixel_y) * COLS_A + AW'(pixel_x);
    wr_data[lmrs_pkg::LIT_RED_BIT]   = (red   != '0);
    wr_data[lmrs_pkg::LIT_GREEN_BIT] = (green != '0);
    wr_data[lmrs_pkg::LIT_BLUE_BIT]  = (blue  != '0);
  end

  lmrs_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .clearing (clearing)
  );

  lmrs_scan_seq #(
    .COLUMNS       (COLUMNS),
    .ROWS_PER_HALF (ROWS_PER_HALF),
    .AW            (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (seq_busy),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .out_valid (byte_valid),
    .out_stall (byte_stall),
    .out_item  (out_item)
  );

  // Unpack the result record onto its ports
  assign serial_byte = out_item.serial_byte;
  assign byte_index  = out_item.byte_index;
  assign last_byte   = out_item.last_byte;
  assign row_select  = out_item.row_select;
  assign display_on  = out_item.display_on;

endmodule

`default_nettype wire
